// ----- sv/fec_pkg.sv -----
// Shared types, codes and constants of the failure event coalescer.
package fec_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ID_W     = 16;
	localparam int KEY_W    = 4 * ID_W;
	localparam int STATUS_W = 4;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = 32;
	localparam int NUM_CNT  = 8;
	localparam int SEL_W    = 3;
	localparam int RES_W    = 3;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_OBSERVE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLAIM   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DISPOSE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

	localparam logic [RES_W-1:0] RES_ACCEPTED   = 3'd0;
	localparam logic [RES_W-1:0] RES_DUPLICATE  = 3'd1;
	localparam logic [RES_W-1:0] RES_CAPACITY   = 3'd2;
	localparam logic [RES_W-1:0] RES_QUEUE_FAIL = 3'd3;

	localparam int CNT_OBSERVED   = 0;
	localparam int CNT_DUPLICATE  = 1;
	localparam int CNT_OVERFLOW   = 2;
	localparam int CNT_ACCEPTED   = 3;
	localparam int CNT_DUP_ADMIT  = 4;
	localparam int CNT_CAPACITY   = 5;
	localparam int CNT_QUEUE_FAIL = 6;
	localparam int CNT_INVALID    = 7;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED,
		ST_DUPLICATE,
		ST_OVERFLOW,
		ST_ZERO_ID,
		ST_CLAIMED,
		ST_NONE_PENDING,
		ST_DISPOSED,
		ST_NO_MATCH,
		ST_COUNTER
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_ACT,
		S_CRD,
		S_CWR,
		S_RESULT
	} fsm_state_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  dest_network_id;
		logic [ID_W-1:0]  dest_node_id;
		logic [ID_W-1:0]  hop_network_id;
		logic [ID_W-1:0]  hop_node_id;
		logic [RES_W-1:0] repair_result;
		logic [SEL_W-1:0] counter_select;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_dest_network_id;
		logic [ID_W-1:0]     out_dest_node_id;
		logic [ID_W-1:0]     out_hop_network_id;
		logic [ID_W-1:0]     out_hop_node_id;
		logic [OCC_W-1:0]    occupancy;
		logic [CNT_W-1:0]    counter_value;
	} rsp_t;

	typedef struct packed {
		logic               capture;
		logic               scan_init;
		logic               scan_run;
		logic               append;
		logic               set_claim;
		logic               clr_claim;
		logic               comp_init;
		logic               comp_rd;
		logic               comp_wr;
		logic               dec_count;
		logic               load_result;
		logic [NUM_CNT-1:0] inc;
		status_t            code;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [RES_W-1:0] repair_result;
		logic             zero_id;
		logic             scan_done;
		logic             found;
		logic             found_claimed;
		logic             full;
		logic             comp_more;
		logic             res_free;
	} sts_t;

endpackage

// ----- sv/fec_req_if.sv -----
// Request channel of the failure event coalescer.
interface fec_req_if import fec_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/fec_rsp_if.sv -----
// Result channel of the failure event coalescer.
interface fec_rsp_if import fec_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/fec_dp.sv -----
// Datapath of the failure event coalescer: entry memory, scan, compaction, counters, result.
module fec_dp import fec_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t in_data,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t out_data,
	output logic out_valid,
	input  logic out_ready
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             claimed;
	} entry_t;

	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;

	req_t             req_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ra_q;
	logic [CW-1:0]    cidx_q;
	logic [CW-1:0]    cidx_plus;
	logic             cmp_v_s1;
	logic [AW-1:0]    cmp_idx_s1;
	logic [AW-1:0]    pos_q;
	logic [KEY_W-1:0] hit_key_q;
	logic             found_q;
	logic             found_claimed_q;
	logic [CNT_W-1:0] cnt_q [NUM_CNT];
	rsp_t             out_q;
	logic             out_valid_q;

	logic [KEY_W-1:0] key_w;
	logic             hit_now;
	logic             issue;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             we;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;

	assign key_w = {req_q.dest_network_id, req_q.dest_node_id,
		req_q.hop_network_id, req_q.hop_node_id};
	assign cidx_plus = cidx_q + CW'(1);

	assign hit_now = cmp_v_s1 && ((req_q.req_type == REQ_CLAIM) ? !rd_q.claimed
		: (rd_q.key == key_w));
	assign issue = cmd.scan_run && !hit_now && (ra_q < count_q);

	always_comb begin
		rd_en   = issue || cmd.comp_rd;
		rd_addr = issue ? ra_q[AW-1:0] : cidx_plus[AW-1:0];
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = pos_q;
		wr_data = '{key: hit_key_q, claimed: 1'b0};
		if (cmd.append) begin
			we      = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = '{key: key_w, claimed: 1'b0};
		end else if (cmd.set_claim) begin
			we      = 1'b1;
			wr_data = '{key: hit_key_q, claimed: 1'b1};
		end else if (cmd.clr_claim) begin
			we = 1'b1;
		end else if (cmd.comp_wr) begin
			we      = 1'b1;
			wr_addr = cidx_q[AW-1:0];
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_init) begin
				cmp_v_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				cmp_v_s1 <= issue;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			for (int i = 0; i < NUM_CNT; i++) begin
				if (cmd.inc[i]) begin
					cnt_q[i] <= cnt_q[i] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
		if (cmd.scan_init) begin
			ra_q <= '0;
		end else if (issue) begin
			ra_q       <= ra_q + CW'(1);
			cmp_idx_s1 <= ra_q[AW-1:0];
		end
		if (cmd.scan_run) begin
			found_q <= hit_now;
			if (hit_now) begin
				pos_q           <= cmp_idx_s1;
				hit_key_q       <= rd_q.key;
				found_claimed_q <= rd_q.claimed;
			end
		end
		if (cmd.comp_init) begin
			cidx_q <= CW'(pos_q);
		end else if (cmd.comp_wr) begin
			cidx_q <= cidx_plus;
		end
		if (cmd.load_result) begin
			out_q.status    <= cmd.code;
			out_q.occupancy <= OCC_W'(count_q);
			if (cmd.code == ST_CLAIMED) begin
				out_q.out_dest_network_id <= hit_key_q[4*ID_W-1:3*ID_W];
				out_q.out_dest_node_id    <= hit_key_q[3*ID_W-1:2*ID_W];
				out_q.out_hop_network_id  <= hit_key_q[2*ID_W-1:ID_W];
				out_q.out_hop_node_id     <= hit_key_q[ID_W-1:0];
			end else begin
				out_q.out_dest_network_id <= '0;
				out_q.out_dest_node_id    <= '0;
				out_q.out_hop_network_id  <= '0;
				out_q.out_hop_node_id     <= '0;
			end
			if (cmd.code == ST_COUNTER) begin
				out_q.counter_value <= cnt_q[req_q.counter_select];
			end else begin
				out_q.counter_value <= '0;
			end
		end
	end

	always_comb begin
		sts.req_type      = req_q.req_type;
		sts.repair_result = req_q.repair_result;
		sts.zero_id       = (req_q.dest_network_id == '0) || (req_q.dest_node_id == '0)
			|| (req_q.hop_network_id == '0) || (req_q.hop_node_id == '0);
		sts.scan_done     = hit_now || (!cmp_v_s1 && !(ra_q < count_q));
		sts.found         = found_q;
		sts.found_claimed = found_claimed_q;
		sts.full          = (count_q >= CW'(MAX_ENTRIES));
		sts.comp_more     = (cidx_plus < count_q);
		sts.res_free      = !out_valid_q || out_ready;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// ----- sv/fec_ctrl.sv -----
// Controller state machine of the failure event coalescer.
module fec_ctrl import fec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_state_t state_q, state_d;
	status_t    code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_ADDED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if ((sts.req_type == REQ_READ)
					|| ((sts.req_type == REQ_OBSERVE) && sts.zero_id)) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				if ((sts.req_type == REQ_DISPOSE) && sts.found && sts.found_claimed
					&& (sts.repair_result != RES_CAPACITY)
					&& (sts.repair_result != RES_QUEUE_FAIL)) begin
					state_d = S_CRD;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_CRD: begin
				state_d = sts.comp_more ? S_CWR : S_RESULT;
			end
			S_CWR: begin
				state_d = S_CRD;
			end
			S_RESULT: begin
				if (sts.res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = code_q;
		code_d   = code_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_START: begin
				if (sts.req_type == REQ_READ) begin
					code_d = ST_COUNTER;
				end else if ((sts.req_type == REQ_OBSERVE) && sts.zero_id) begin
					code_d = ST_ZERO_ID;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			S_ACT: begin
				case (sts.req_type)
					REQ_OBSERVE: begin
						cmd.inc[CNT_OBSERVED] = 1'b1;
						if (sts.found) begin
							cmd.inc[CNT_DUPLICATE] = 1'b1;
							code_d = ST_DUPLICATE;
						end else if (sts.full) begin
							cmd.inc[CNT_OVERFLOW] = 1'b1;
							code_d = ST_OVERFLOW;
						end else begin
							cmd.append = 1'b1;
							code_d     = ST_ADDED;
						end
					end
					REQ_CLAIM: begin
						if (sts.found) begin
							cmd.set_claim = 1'b1;
							code_d        = ST_CLAIMED;
						end else begin
							code_d = ST_NONE_PENDING;
						end
					end
					REQ_DISPOSE: begin
						if (sts.found && sts.found_claimed) begin
							code_d = ST_DISPOSED;
							case (sts.repair_result)
								RES_ACCEPTED: begin
									cmd.inc[CNT_ACCEPTED] = 1'b1;
									cmd.comp_init = 1'b1;
								end
								RES_DUPLICATE: begin
									cmd.inc[CNT_DUP_ADMIT] = 1'b1;
									cmd.comp_init = 1'b1;
								end
								RES_CAPACITY: begin
									cmd.inc[CNT_CAPACITY] = 1'b1;
									cmd.clr_claim = 1'b1;
								end
								RES_QUEUE_FAIL: begin
									cmd.inc[CNT_QUEUE_FAIL] = 1'b1;
									cmd.clr_claim = 1'b1;
								end
								default: begin
									cmd.inc[CNT_INVALID] = 1'b1;
									cmd.comp_init = 1'b1;
								end
							endcase
						end else begin
							code_d = ST_NO_MATCH;
						end
					end
					default: begin
						code_d = ST_COUNTER;
					end
				endcase
			end
			S_CRD: begin
				if (sts.comp_more) begin
					cmd.comp_rd = 1'b1;
				end else begin
					cmd.dec_count = 1'b1;
				end
			end
			S_CWR: begin
				cmd.comp_wr = 1'b1;
			end
			S_RESULT: begin
				cmd.load_result = sts.res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- sv/failure_event_coalescer_core.sv -----
// Top level of the failure event coalescer: controller, datapath and checks.
//
// Requests arrive on the req channel and each produces exactly one result beat on
// the rsp channel; a beat moves when valid and ready are both high. One request is
// worked on at a time, and req.ready is high only while the controller is idle.
// A counter read or a rejected observe goes from the start state straight to
// the result state. Other requests scan the entry memory at one entry per cycle,
// up to the first match or the last of the entries held. A dispose that removes
// an entry then closes the gap, moving each entry behind it down by one through
// a read state and a write state, since the entry memory has a single read port.
// The result sits in an output register, so the next request is accepted while a
// result still waits; when rsp.ready stays low the block finishes that next request
// and holds it until the waiting beat is taken.
// Reset empties the table and clears all eight statistics counters at once; no
// clearing pass is needed, and the block accepts requests from the first cycle.
module failure_event_coalescer_core import fec_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fec_req_if.sink   req,
	fec_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	fec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fec_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (rsp.data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("Request accepted while another was still being worked on.");

	a_key_only_on_claim: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.status != ST_CLAIMED)) |->
		((rsp.data.out_dest_network_id == '0) && (rsp.data.out_dest_node_id == '0)
		&& (rsp.data.out_hop_network_id == '0) && (rsp.data.out_hop_node_id == '0)))
		else $error("Key fields set on a result that is not a claim.");

	a_value_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.status != ST_COUNTER)) |-> (rsp.data.counter_value == '0))
		else $error("Counter value set on a result that is not a counter read.");

endmodule

// ----- bench/fec_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker of the failure event coalescer: predicts every result beat and compares it.
module fec_result_checker import fec_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_beat,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_beat,
	output int   mismatches,
	output int   outstanding,
	output int   claims_seen,
	output int   overflows_seen,
	output int   disposals_seen
);
	logic [KEY_W-1:0] event_key [MAX_ENTRIES];
	logic             event_claimed [MAX_ENTRIES];
	int               events_held;
	logic [CNT_W-1:0] stat_count [NUM_CNT];
	rsp_t             expected_results [$];
	int               fail_total = 0;
	int               pending_total = 0;
	int               claim_total = 0;
	int               overflow_total = 0;
	int               dispose_total = 0;

	assign mismatches     = fail_total;
	assign outstanding    = pending_total;
	assign claims_seen    = claim_total;
	assign overflows_seen = overflow_total;
	assign disposals_seen = dispose_total;

	function automatic rsp_t coalesce_request(req_t r);
		rsp_t             o;
		logic [KEY_W-1:0] key;
		int               pos;
		int               i;
		logic             drop;
		o = '0;
		pos = -1;
		drop = 1'b0;
		key = {r.dest_network_id, r.dest_node_id, r.hop_network_id, r.hop_node_id};
		for (i = 0; i < events_held; i++)
			if (pos < 0 && event_key[i] == key)
				pos = i;
		case (r.req_type)
			REQ_OBSERVE: begin
				if (r.dest_network_id == '0 || r.dest_node_id == '0 ||
				    r.hop_network_id == '0 || r.hop_node_id == '0) begin
					o.status = ST_ZERO_ID;
				end else begin
					stat_count[CNT_OBSERVED]++;
					if (pos >= 0) begin
						stat_count[CNT_DUPLICATE]++;
						o.status = ST_DUPLICATE;
					end else if (events_held >= MAX_ENTRIES) begin
						stat_count[CNT_OVERFLOW]++;
						o.status = ST_OVERFLOW;
					end else begin
						event_key[events_held] = key;
						event_claimed[events_held] = 1'b0;
						events_held++;
						o.status = ST_ADDED;
					end
				end
			end
			REQ_CLAIM: begin
				o.status = ST_NONE_PENDING;
				for (i = 0; i < events_held; i++) begin
					if (o.status == ST_NONE_PENDING && !event_claimed[i]) begin
						event_claimed[i] = 1'b1;
						{o.out_dest_network_id, o.out_dest_node_id,
						 o.out_hop_network_id, o.out_hop_node_id} = event_key[i];
						o.status = ST_CLAIMED;
					end
				end
			end
			REQ_DISPOSE: begin
				if (pos >= 0 && event_claimed[pos]) begin
					o.status = ST_DISPOSED;
					case (r.repair_result)
						RES_ACCEPTED: begin
							stat_count[CNT_ACCEPTED]++;
							drop = 1'b1;
						end
						RES_DUPLICATE: begin
							stat_count[CNT_DUP_ADMIT]++;
							drop = 1'b1;
						end
						RES_CAPACITY: begin
							stat_count[CNT_CAPACITY]++;
							event_claimed[pos] = 1'b0;
						end
						RES_QUEUE_FAIL: begin
							stat_count[CNT_QUEUE_FAIL]++;
							event_claimed[pos] = 1'b0;
						end
						default: begin
							stat_count[CNT_INVALID]++;
							drop = 1'b1;
						end
					endcase
					if (drop) begin
						for (i = pos; i + 1 < events_held; i++) begin
							event_key[i] = event_key[i + 1];
							event_claimed[i] = event_claimed[i + 1];
						end
						events_held--;
					end
				end else begin
					o.status = ST_NO_MATCH;
				end
			end
			default: begin
				o.status = ST_COUNTER;
				o.counter_value = stat_count[r.counter_select];
			end
		endcase
		o.occupancy = OCC_W'(events_held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			events_held = 0;
			for (int i = 0; i < NUM_CNT; i++)
				stat_count[i] = '0;
			expected_results.delete();
			pending_total = 0;
		end else begin
			// The result beat is checked before a request taken at the same edge is predicted.
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: result beat with nothing expected: status %0d key %h occ %0d cnt %h",
							$time, rsp_beat.status,
							{rsp_beat.out_dest_network_id, rsp_beat.out_dest_node_id,
							 rsp_beat.out_hop_network_id, rsp_beat.out_hop_node_id},
							rsp_beat.occupancy, rsp_beat.counter_value);
					fail_total++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_beat.status !== want.status ||
					    rsp_beat.out_dest_network_id !== want.out_dest_network_id ||
					    rsp_beat.out_dest_node_id !== want.out_dest_node_id ||
					    rsp_beat.out_hop_network_id !== want.out_hop_network_id ||
					    rsp_beat.out_hop_node_id !== want.out_hop_node_id ||
					    rsp_beat.occupancy !== want.occupancy ||
					    rsp_beat.counter_value !== want.counter_value) begin
						if (fail_total < 10)
							$display("%0t: expected status %0d key %h occ %0d cnt %h, got status %0d key %h occ %0d cnt %h",
								$time, want.status,
								{want.out_dest_network_id, want.out_dest_node_id,
								 want.out_hop_network_id, want.out_hop_node_id},
								want.occupancy, want.counter_value, rsp_beat.status,
								{rsp_beat.out_dest_network_id, rsp_beat.out_dest_node_id,
								 rsp_beat.out_hop_network_id, rsp_beat.out_hop_node_id},
								rsp_beat.occupancy, rsp_beat.counter_value);
						fail_total++;
					end
				end
			end
			if (req_valid && req_ready) begin
				want = coalesce_request(req_beat);
				if (want.status == ST_CLAIMED)
					claim_total++;
				if (want.status == ST_OVERFLOW)
					overflow_total++;
				if (want.status == ST_DISPOSED)
					dispose_total++;
				expected_results.push_back(want);
			end
			pending_total = expected_results.size();
		end
	end
endmodule

// ----- bench/failure_event_coalescer_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top of the failure event coalescer: stimulus, idling, watchdog and verdict.
module failure_event_coalescer_core_tb;
	import fec_pkg::*;

	localparam int POOL_SIZE      = 20;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 241;
	localparam int TAIL_CYCLES    = 3 * MAX_ENTRIES_DEF + 16;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [RES_W-1:0] RES_OUT_OF_RANGE = 3'd7;
	localparam logic [KEY_W-1:0] KEY_ALL_ONES     = {4{16'hFFFF}};
	localparam logic [KEY_W-1:0] KEY_LOWEST       = {4{16'h0001}};

	logic             clk;
	logic             arst_n;
	int               src_idle;
	int               sink_stall;
	int               quiet_cycles;
	int               requests_sent;
	int               key_window;
	int               mismatches;
	int               outstanding;
	int               claims_seen;
	int               overflows_seen;
	int               disposals_seen;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	fec_req_if req_ch ();
	fec_rsp_if rsp_ch ();

	failure_event_coalescer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	fec_result_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_beat(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_beat(rsp_ch.data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.claims_seen(claims_seen),
		.overflows_seen(overflows_seen),
		.disposals_seen(disposals_seen)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without a beat.", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic req_t make_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [RES_W-1:0] outcome, logic [SEL_W-1:0] sel);
		req_t r;
		r.req_type = kind;
		{r.dest_network_id, r.dest_node_id, r.hop_network_id, r.hop_node_id} = key;
		r.repair_result = outcome;
		r.counter_select = sel;
		return r;
	endfunction

	// Observes draw from a window of the key pool, so the table fills or overflows as the
	// window grows; nine in ten disposes draw from the whole pool, so no entry is left stranded.
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		r.dest_network_id = ID_W'($urandom);
		r.dest_node_id = ID_W'($urandom);
		r.hop_network_id = ID_W'($urandom);
		r.hop_node_id = ID_W'($urandom);
		r.repair_result = RES_W'($urandom_range(0, 7));
		r.counter_select = SEL_W'($urandom_range(0, 7));
		if (pick < 40) begin
			r.req_type = REQ_OBSERVE;
			{r.dest_network_id, r.dest_node_id, r.hop_network_id, r.hop_node_id} =
				key_pool[$urandom_range(0, key_window - 1)];
			if ($urandom_range(0, 99) < 6) begin
				case ($urandom_range(0, 3))
					0: r.dest_network_id = '0;
					1: r.dest_node_id = '0;
					2: r.hop_network_id = '0;
					default: r.hop_node_id = '0;
				endcase
			end
		end else if (pick < 65) begin
			r.req_type = REQ_CLAIM;
		end else if (pick < 90) begin
			r.req_type = REQ_DISPOSE;
			if ($urandom_range(0, 9) != 0)
				{r.dest_network_id, r.dest_node_id, r.hop_network_id, r.hop_node_id} =
					key_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else begin
			r.req_type = REQ_READ;
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		src_idle = 0;
		sink_stall = 0;
		quiet_cycles = 0;
		requests_sent = 0;
		key_window = POOL_SIZE;
		// Every second key differs from its neighbour in one id only.
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {ID_W'($urandom_range(1, 65535)), ID_W'($urandom_range(1, 65535)),
				ID_W'($urandom_range(1, 65535)), ID_W'($urandom_range(1, 65535))};
			if (i % 2 == 1) begin
				key_pool[i] = key_pool[i - 1];
				key_pool[i][ID_W * $urandom_range(0, 3) +: ID_W] = ID_W'($urandom_range(1, 65535));
			end
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(make_request(REQ_READ, '0, RES_ACCEPTED, SEL_W'(CNT_OBSERVED)));
		send_request(make_request(REQ_CLAIM, KEY_ALL_ONES, RES_ACCEPTED, '0));
		send_request(make_request(REQ_DISPOSE, KEY_ALL_ONES, RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, {16'h0000, {3{16'hFFFF}}}, RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, {16'hFFFF, 16'h0000, {2{16'hFFFF}}},
			RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, {{2{16'hFFFF}}, 16'h0000, 16'hFFFF},
			RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, {{3{16'hFFFF}}, 16'h0000}, RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, KEY_ALL_ONES, RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, KEY_LOWEST, RES_ACCEPTED, '0));
		send_request(make_request(REQ_OBSERVE, KEY_ALL_ONES, RES_ACCEPTED, '0));
		send_request(make_request(REQ_DISPOSE, KEY_ALL_ONES, RES_ACCEPTED, '0));
		send_request(make_request(REQ_CLAIM, '0, RES_ACCEPTED, '0));
		send_request(make_request(REQ_DISPOSE, KEY_ALL_ONES, RES_CAPACITY, '0));
		send_request(make_request(REQ_CLAIM, '0, RES_ACCEPTED, '0));
		send_request(make_request(REQ_DISPOSE, KEY_ALL_ONES, RES_QUEUE_FAIL, '0));
		send_request(make_request(REQ_CLAIM, '0, RES_ACCEPTED, '0));
		send_request(make_request(REQ_CLAIM, '0, RES_ACCEPTED, '0));
		send_request(make_request(REQ_CLAIM, '0, RES_ACCEPTED, '0));
		send_request(make_request(REQ_DISPOSE, KEY_ALL_ONES, RES_DUPLICATE, '0));
		send_request(make_request(REQ_DISPOSE, KEY_LOWEST, RES_OUT_OF_RANGE, '0));
		send_request(make_request(REQ_READ, '0, RES_ACCEPTED, SEL_W'(CNT_INVALID)));
		send_request(make_request(REQ_READ, '0, RES_ACCEPTED, SEL_W'(CNT_DUP_ADMIT)));
		wait_results_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			@(posedge clk);
			case (phase % 4)
				0: begin
					src_idle = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle = 78;
					sink_stall = 0;
				end
				2: begin
					src_idle = 0;
					sink_stall = 78;
				end
				default: begin
					src_idle = 15;
					sink_stall = 15;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 49) == 0)
					key_window = $urandom_range(4, POOL_SIZE);
				send_request(random_request());
			end
			wait_results_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d requests under four idling modes with drained pauses between them.",
			requests_sent);
		$display("Results included %0d claims, %0d overflows and %0d disposals.",
			claims_seen, overflows_seen, disposals_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
